/* rtl/calendar_clock_tick_macros.svh */
// ----------------------------------------------------------------------------
// calendar clock tick assertion macros
// shared concurrent assertion forms for the calendar counter
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_TICK_MACROS_SVH
`define CALENDAR_CLOCK_TICK_MACROS_SVH

// same-cycle implication, checked outside reset
`define CCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cct_pkg.sv */
// ----------------------------------------------------------------------------
// cct_pkg
// types, constants and helpers shared by the calendar clock tick block
// ----------------------------------------------------------------------------
package cct_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // default year wrap point
    localparam int YEAR_LIMIT_DEF = 9999;

    // field limits
    localparam logic [SECOND_W-1:0] SEC_MAX   = 6'd59;
    localparam logic [MINUTE_W-1:0] MIN_MAX   = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_MAX  = 5'd23;
    localparam logic [MONTH_W-1:0]  MONTH_MAX = 4'd12;
    localparam logic [MONTH_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [DAY_W-1:0]    FEB_DAYS  = 5'd28;

    // reset time
    localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd1900;

    // divisibility by 25 of a 12-bit value: multiply by the inverse of 25
    // modulo 2^12, a multiple of 25 lands at or below 4095/25
    localparam logic [11:0] INV25     = 12'd3113;
    localparam logic [11:0] DIV25_LIM = 12'd163;

    // command codes
    typedef enum logic [1:0] {
        MODE_FWD  = 2'd0,
        MODE_BACK = 2'd1,
        MODE_LOAD = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    // calendar time
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_time;

    // input item
    typedef struct packed {
        t_mode               mode;
        logic [YEAR_W-1:0]   load_year;
        logic [MONTH_W-1:0]  load_month;
        logic [DAY_W-1:0]    load_day;
        logic [HOUR_W-1:0]   load_hour;
        logic [MINUTE_W-1:0] load_minute;
        logic [SECOND_W-1:0] load_second;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [YEAR_W-1:0]   cur_year;
        logic [MONTH_W-1:0]  cur_month;
        logic [DAY_W-1:0]    cur_day;
        logic [HOUR_W-1:0]   cur_hour;
        logic [MINUTE_W-1:0] cur_minute;
        logic [SECOND_W-1:0] cur_second;
        logic                day_rollover;
    } t_out_item;

    // days in a month, month codes outside 1..12 read as january
    function automatic logic [DAY_W-1:0] month_len(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        unique case (month)
            MONTH_FEB: begin
                len = leap ? FEB_DAYS + 5'd1 : FEB_DAYS;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

/* rtl/cct_leap.sv */
// ----------------------------------------------------------------------------
// cct_leap
// gregorian leap year test on a 14-bit year
// ----------------------------------------------------------------------------
module cct_leap (
    input  logic [cct_pkg::YEAR_W-1:0] i_year,
    output logic                       o_leap
);

    logic [cct_pkg::YEAR_W-3:0] w_quarter;
    logic [11:0]                w_prod;
    logic                       w_div25;

    // year / 4, then test it against 25 with the modular inverse
    assign w_quarter = i_year[cct_pkg::YEAR_W-1:2];
    assign w_prod    = 12'(w_quarter * cct_pkg::INV25);
    assign w_div25   = (w_prod <= cct_pkg::DIV25_LIM);

    // divisible by 4, and not a century unless divisible by 400
    assign o_leap = (i_year[1:0] == 2'd0) && (!w_div25 || (w_quarter[1:0] == 2'd0));

endmodule

/* rtl/cct_adv.sv */
// ----------------------------------------------------------------------------
// cct_adv
// next calendar time for one command: tick forward, tick back, load, read
// ----------------------------------------------------------------------------
module cct_adv #(
    parameter int YEAR_LIMIT = cct_pkg::YEAR_LIMIT_DEF
) (
    input  cct_pkg::t_time             i_state,
    input  cct_pkg::t_in_item          i_item,
    input  logic                       i_leap,
    output logic [cct_pkg::YEAR_W-1:0] o_leap_year,
    output cct_pkg::t_time             o_next,
    output logic                       o_roll
);

    localparam logic [cct_pkg::YEAR_W-1:0] YearMax = cct_pkg::YEAR_W'(YEAR_LIMIT);

    logic [cct_pkg::YEAR_W-1:0]  w_ld_year;
    logic [cct_pkg::MONTH_W-1:0] w_ld_month;
    logic [cct_pkg::MONTH_W-1:0] w_prev_month;
    logic [cct_pkg::DAY_W-1:0]   w_len_fwd;
    logic [cct_pkg::DAY_W-1:0]   w_len_back;
    logic [cct_pkg::DAY_W-1:0]   w_len_load;

    // clamped load year and month
    assign w_ld_year = (i_item.load_year > YearMax) ? YearMax : i_item.load_year;
    always_comb begin
        if (i_item.load_month == '0) begin
            w_ld_month = 4'd1;
        end else if (i_item.load_month > cct_pkg::MONTH_MAX) begin
            w_ld_month = cct_pkg::MONTH_MAX;
        end else begin
            w_ld_month = i_item.load_month;
        end
    end

    // year whose leap flag matters for this command
    assign o_leap_year = (i_item.mode == cct_pkg::MODE_LOAD) ? w_ld_year : i_state.year;

    // month lengths; going back into february keeps the same year
    assign w_prev_month = (i_state.month > 4'd1) ? i_state.month - 4'd1 : cct_pkg::MONTH_MAX;
    assign w_len_fwd    = cct_pkg::month_len(i_state.month, i_leap);
    assign w_len_back   = cct_pkg::month_len(w_prev_month, i_leap);
    assign w_len_load   = cct_pkg::month_len(w_ld_month, i_leap);

    // carry and borrow ripple for the tick commands, clamped load, hold on read
    always_comb begin
        o_next = i_state;
        o_roll = 1'b0;
        unique case (i_item.mode)
            cct_pkg::MODE_FWD: begin
                if (i_state.second < cct_pkg::SEC_MAX) begin
                    o_next.second = i_state.second + 6'd1;
                end else begin
                    o_next.second = '0;
                    if (i_state.minute < cct_pkg::MIN_MAX) begin
                        o_next.minute = i_state.minute + 6'd1;
                    end else begin
                        o_next.minute = '0;
                        if (i_state.hour < cct_pkg::HOUR_MAX) begin
                            o_next.hour = i_state.hour + 5'd1;
                        end else begin
                            o_next.hour = '0;
                            o_roll      = 1'b1;
                            if (i_state.day < w_len_fwd) begin
                                o_next.day = i_state.day + 5'd1;
                            end else begin
                                o_next.day = 5'd1;
                                if (i_state.month < cct_pkg::MONTH_MAX) begin
                                    o_next.month = i_state.month + 4'd1;
                                end else begin
                                    o_next.month = 4'd1;
                                    o_next.year  = (i_state.year < YearMax) ?
                                                   i_state.year + 14'd1 : '0;
                                end
                            end
                        end
                    end
                end
            end
            cct_pkg::MODE_BACK: begin
                if (i_state.second > '0) begin
                    o_next.second = i_state.second - 6'd1;
                end else begin
                    o_next.second = cct_pkg::SEC_MAX;
                    if (i_state.minute > '0) begin
                        o_next.minute = i_state.minute - 6'd1;
                    end else begin
                        o_next.minute = cct_pkg::MIN_MAX;
                        if (i_state.hour > '0) begin
                            o_next.hour = i_state.hour - 5'd1;
                        end else begin
                            o_next.hour = cct_pkg::HOUR_MAX;
                            o_roll      = 1'b1;
                            if (i_state.day > 5'd1) begin
                                o_next.day = i_state.day - 5'd1;
                            end else begin
                                o_next.month = w_prev_month;
                                o_next.day   = w_len_back;
                                if (i_state.month <= 4'd1) begin
                                    o_next.year = (i_state.year > '0) ?
                                                  i_state.year - 14'd1 : YearMax;
                                end
                            end
                        end
                    end
                end
            end
            cct_pkg::MODE_LOAD: begin
                o_next.year  = w_ld_year;
                o_next.month = w_ld_month;
                if (i_item.load_day == '0) begin
                    o_next.day = 5'd1;
                end else if (i_item.load_day > w_len_load) begin
                    o_next.day = w_len_load;
                end else begin
                    o_next.day = i_item.load_day;
                end
                o_next.hour   = (i_item.load_hour > cct_pkg::HOUR_MAX) ?
                                cct_pkg::HOUR_MAX : i_item.load_hour;
                o_next.minute = (i_item.load_minute > cct_pkg::MIN_MAX) ?
                                cct_pkg::MIN_MAX : i_item.load_minute;
                o_next.second = (i_item.load_second > cct_pkg::SEC_MAX) ?
                                cct_pkg::SEC_MAX : i_item.load_second;
            end
            cct_pkg::MODE_READ: begin
                o_next = i_state;
            end
            default: begin
                o_next = i_state;
            end
        endcase
    end

endmodule

/* rtl/calendar_clock_tick.sv */
// ----------------------------------------------------------------------------
// calendar_clock_tick
// real-time-clock calendar counter with gregorian months and year wrap
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in_item  (cct_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready o_out_item (cct_pkg::t_out_item)
//
// one item per cycle sustained while the output is taken; an accepted item moves
// from the input register through one carry pass into the result register
// the time registers update on the same edge the result is written, so the next
// item in the input register always sees the time left by the one before it
// a stalled output holds the result; the input register still takes one more
// item, then o_in_ready drops until the result is taken
// synchronous active-low reset gives 1900-01-01 00:00:00 and empty registers
// ----------------------------------------------------------------------------
`include "calendar_clock_tick_macros.svh"

module calendar_clock_tick #(
    parameter int YEAR_LIMIT = cct_pkg::YEAR_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cct_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cct_pkg::t_out_item o_out_item
);

    cct_pkg::t_in_item          r_in;
    logic                       r_in_valid;
    cct_pkg::t_time             r_time;
    cct_pkg::t_out_item         r_out;
    logic                       r_out_valid;

    cct_pkg::t_time             n_time;
    logic                       w_roll;
    logic                       w_leap;
    logic [cct_pkg::YEAR_W-1:0] w_leap_year;
    logic                       w_move;

    logic                       w_out_sync;
    logic                       w_month_ok;
    logic                       w_roll_out;
    logic                       w_at_midnight;

    // stage handshake
    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // leap test on the relevant year
    cct_leap u_leap (
        .i_year (w_leap_year),
        .o_leap (w_leap)
    );

    // next time for the held command
    cct_adv #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_adv (
        .i_state     (r_time),
        .i_item      (r_in),
        .i_leap      (w_leap),
        .o_leap_year (w_leap_year),
        .o_next      (n_time),
        .o_roll      (w_roll)
    );

    // time registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.year   <= cct_pkg::RESET_YEAR;
            r_time.month  <= 4'd1;
            r_time.day    <= 5'd1;
            r_time.hour   <= '0;
            r_time.minute <= '0;
            r_time.second <= '0;
        end else if (w_move) begin
            r_time <= n_time;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_move) begin
            r_out.cur_year     <= n_time.year;
            r_out.cur_month    <= n_time.month;
            r_out.cur_day      <= n_time.day;
            r_out.cur_hour     <= n_time.hour;
            r_out.cur_minute   <= n_time.minute;
            r_out.cur_second   <= n_time.second;
            r_out.day_rollover <= w_roll;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // terms for the checks
    assign w_out_sync    = o_out_valid && (o_out_item.cur_second == r_time.second);
    assign w_month_ok    = (r_time.month >= 4'd1) && (r_time.month <= cct_pkg::MONTH_MAX);
    assign w_roll_out    = o_out_valid && o_out_item.day_rollover;
    assign w_at_midnight = ((o_out_item.cur_hour == '0) && (o_out_item.cur_minute == '0) &&
                            (o_out_item.cur_second == '0)) ||
                           ((o_out_item.cur_hour == cct_pkg::HOUR_MAX) &&
                            (o_out_item.cur_minute == cct_pkg::MIN_MAX) &&
                            (o_out_item.cur_second == cct_pkg::SEC_MAX));

    // checks
    `CCT_ASSERT_NEXT(a_move_fills_out, i_clk, i_rst_n, w_move, w_out_sync, "result lost")
    `CCT_ASSERT_NOW(a_month_range, i_clk, i_rst_n, 1'b1, w_month_ok, "month out of range")
    `CCT_ASSERT_NOW(a_roll_midnight, i_clk, i_rst_n, w_roll_out, w_at_midnight, "bad rollover")

endmodule
